/* rtl/aks_pkg.sv */
package aks_pkg;

    localparam int OP_W          = 1;
    localparam int FRAME_IDX_W   = 4;
    localparam int DURATION_W    = 16;
    localparam int ELAPSED_W     = 16;
    localparam int FRAME_NUM_W   = 4;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 5;
    localparam int FIRST_W       = 4;
    localparam int COUNT_W       = 5;

    localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
    localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LOOP_FRAME = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT      = 2'd2;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 5'd1;

endpackage

/* rtl/aks_in_if.sv */
interface aks_in_if;
    logic                             valid;
    logic                             ready;
    logic [aks_pkg::OP_W-1:0]         op;
    logic [aks_pkg::FRAME_IDX_W-1:0]  frame_index;
    logic [aks_pkg::DURATION_W-1:0]   duration;
    logic [aks_pkg::ELAPSED_W-1:0]    elapsed_time;

    modport source (output valid, op, frame_index, duration, elapsed_time, input ready);
    modport sink   (input valid, op, frame_index, duration, elapsed_time, output ready);
endinterface

/* rtl/aks_out_if.sv */
interface aks_out_if;
    logic                             valid;
    logic                             ready;
    logic [aks_pkg::FRAME_NUM_W-1:0]  frame_number;
    logic                             clamped;
    logic                             bad_timing;

    modport source (output valid, frame_number, clamped, bad_timing, input ready);
    modport sink   (input valid, frame_number, clamped, bad_timing, output ready);
endinterface

/* rtl/aks_ram.sv */
module aks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/aks_mod.sv */
module aks_mod #(
    parameter int TW = 16,
    parameter int SW = 21
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [TW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_rem
);

    localparam int CNT_W = $clog2(TW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SW-1:0]    r_rem;
    logic [TW-1:0]    r_dvd;
    logic [SW-1:0]    r_div;

    logic [SW:0]      shifted;
    logic [SW:0]      diff;
    logic [SW-1:0]    n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[TW-1]};
        diff    = shifted - {1'b0, r_div};
        n_rem   = (shifted >= {1'b0, r_div}) ? diff[SW-1:0] : shifted[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(TW - 1);
                r_rem  <= '0;
                r_dvd  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* rtl/animation_keyframe_select.sv */
// Duration write: accepted, no result.
// Query: result registered after at most two walks over the one-read-port duration memory
// (one to sum the durations, one to find the frame), with the one-bit-per-cycle modulo unit
// between them when a looped time is folded; the result is held back while the output is stalled.
// One item in flight at a time; the next item can be accepted once the result registers.
// Synchronous reset restores the configuration registers and control state only.
module animation_keyframe_select #(
    parameter int MAX_FRAMES = 16,
    parameter int TIME_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aks_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aks_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    aks_in_if.sink                          i_in,
    aks_out_if.source                       o_out
);

    localparam int IW = $clog2(MAX_FRAMES);
    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int TW = TIME_BITS;
    localparam int SW = TIME_BITS + CW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SUM    = 6'b000010,
        S_DECIDE = 6'b000100,
        S_MOD    = 6'b001000,
        S_WALK   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_loop_en;
    logic [aks_pkg::FIRST_W-1:0]   r_first_cfg;
    logic [aks_pkg::COUNT_W-1:0]   r_fc;
    logic [CW-1:0]                 r_n, n_n;
    logic [CW-1:0]                 r_first, n_first;
    logic [CW-1:0]                 r_addr, n_addr;
    logic                          r_dv, n_dv;
    logic [CW-1:0]                 r_didx, n_didx;
    logic [SW-1:0]                 r_total, n_total;
    logic [SW-1:0]                 r_intro, n_intro;
    logic [SW-1:0]                 r_t, n_t;
    logic [IW-1:0]                 r_frame, n_frame;
    logic                          r_clamped, n_clamped;
    logic                          r_bad, n_bad;
    logic                          r_out_valid, n_out_valid;
    logic [aks_pkg::FRAME_NUM_W-1:0] r_out_frame, n_out_frame;
    logic                          r_out_clamped, n_out_clamped;
    logic                          r_out_bad, n_out_bad;

    logic                          accept;
    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    logic [TW-1:0]                 ram_wdata;
    logic [TW-1:0]                 ram_q;
    logic [SW-1:0]                 ram_q_ext;
    logic                          mod_start;
    logic [TW-1:0]                 mod_dividend;
    logic                          mod_done;
    logic [SW-1:0]                 mod_rem;

    logic [31:0]                   idx32, dur32, el32, fc32, n32, first32, fr32;
    logic [CW-1:0]                 last;
    logic                          issue;
    logic [SW-1:0]                 t_minus_intro;
    logic                          out_free;

    aks_ram #(
        .WIDTH (TW),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_q)
    );

    aks_mod #(
        .TW (TW),
        .SW (SW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (r_total - r_intro),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign i_in.ready         = (r_state == S_IDLE);
    assign accept             = i_in.valid && i_in.ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.frame_number = r_out_frame;
    assign o_out.clamped      = r_out_clamped;
    assign o_out.bad_timing   = r_out_bad;

    always_comb begin
        idx32   = 32'(i_in.frame_index);
        dur32   = 32'(i_in.duration);
        el32    = 32'(i_in.elapsed_time);
        fc32    = 32'(r_fc);
        if (fc32 == 32'd0) begin
            n32 = 32'd1;
        end else if (fc32 > 32'(MAX_FRAMES)) begin
            n32 = 32'(MAX_FRAMES);
        end else begin
            n32 = fc32;
        end
        first32 = 32'(r_first_cfg);
        if (first32 > n32) begin
            first32 = n32;
        end
        fr32 = 32'(r_frame);

        ram_we    = accept && (i_in.op == aks_pkg::OP_LOAD) && (idx32 < 32'(MAX_FRAMES));
        ram_waddr = idx32[IW-1:0];
        ram_wdata = dur32[TW-1:0];
        ram_q_ext = {{(SW-TW){1'b0}}, ram_q};

        last          = r_n - 1'b1;
        issue         = (r_addr < r_n);
        t_minus_intro = r_t - r_intro;
        mod_dividend  = t_minus_intro[TW-1:0];
        mod_start     = 1'b0;
        out_free      = !r_out_valid || o_out.ready;

        n_state       = r_state;
        n_n           = r_n;
        n_first       = r_first;
        n_addr        = r_addr;
        n_dv          = 1'b0;
        n_didx        = r_addr;
        n_total       = r_total;
        n_intro       = r_intro;
        n_t           = r_t;
        n_frame       = r_frame;
        n_clamped     = r_clamped;
        n_bad         = r_bad;
        n_out_valid   = r_out_valid;
        n_out_frame   = r_out_frame;
        n_out_clamped = r_out_clamped;
        n_out_bad     = r_out_bad;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_in.op == aks_pkg::OP_QUERY)) begin
                    n_n       = n32[CW-1:0];
                    n_first   = first32[CW-1:0];
                    n_addr    = '0;
                    n_total   = '0;
                    n_intro   = '0;
                    n_t       = {{(SW-TW){1'b0}}, el32[TW-1:0]};
                    n_clamped = 1'b0;
                    n_bad     = 1'b0;
                    n_state   = S_SUM;
                end
            end
            S_SUM: begin
                n_dv = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_dv) begin
                    n_total = r_total + ram_q_ext;
                    if (r_didx < r_first) begin
                        n_intro = r_intro + ram_q_ext;
                    end
                    if (r_didx == last) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                n_frame = last[IW-1:0];
                n_addr  = '0;
                if (r_total == '0) begin
                    n_bad   = 1'b1;
                    n_state = S_DONE;
                end else if (r_t >= r_total) begin
                    if (!r_loop_en) begin
                        n_clamped = 1'b1;
                        n_state   = S_DONE;
                    end else if (r_total == r_intro) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = S_MOD;
                    end
                end else begin
                    n_state = S_WALK;
                end
            end
            S_MOD: begin
                if (mod_done) begin
                    n_t     = r_intro + mod_rem;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                n_dv = issue;
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end
                if (r_dv) begin
                    if (r_t < ram_q_ext) begin
                        n_frame = r_didx[IW-1:0];
                        n_state = S_DONE;
                    end else begin
                        n_t = r_t - ram_q_ext;
                        if (r_didx == last) begin
                            n_frame = last[IW-1:0];
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_frame   = fr32[aks_pkg::FRAME_NUM_W-1:0];
                    n_out_clamped = r_clamped;
                    n_out_bad     = r_bad;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_loop_en   <= 1'b0;
            r_first_cfg <= '0;
            r_fc        <= aks_pkg::FRAME_COUNT_RESET;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    aks_pkg::CFG_LOOP_ENABLE:      r_loop_en   <= i_cfg_data[0];
                    aks_pkg::CFG_FIRST_LOOP_FRAME: r_first_cfg <= i_cfg_data[aks_pkg::FIRST_W-1:0];
                    aks_pkg::CFG_FRAME_COUNT:      r_fc        <= i_cfg_data[aks_pkg::COUNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n           <= n_n;
        r_first       <= n_first;
        r_addr        <= n_addr;
        r_didx        <= n_didx;
        r_total       <= n_total;
        r_intro       <= n_intro;
        r_t           <= n_t;
        r_frame       <= n_frame;
        r_clamped     <= n_clamped;
        r_bad         <= n_bad;
        r_out_frame   <= n_out_frame;
        r_out_clamped <= n_out_clamped;
        r_out_bad     <= n_out_bad;
    end

endmodule
